// ===== hw/rtl/chacha_pkg.sv =====
// Shared constants and types for the ChaCha20 stream cipher.
// Used by the controller, the datapath and the top level.
package chacha_pkg;
  localparam logic [31:0] SIGMA0 = 32'h61707865;
  localparam logic [31:0] SIGMA1 = 32'h3320646e;
  localparam logic [31:0] SIGMA2 = 32'h79622d32;
  localparam logic [31:0] SIGMA3 = 32'h6b206574;
  localparam int DOUBLE_ROUNDS = 10;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] REG_KEY0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NONCE_LO = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_NONCE_HI = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_CTR = 3'd6;

  // Controller to datapath.
  typedef struct packed {
    logic load;      // load initial state from config and counter
    logic round;     // apply one half round (column or diagonal)
    logic diag;      // half round is the diagonal one
    logic finish;    // feed-forward add into the keystream block
    logic advance;   // take an item, update position and block index
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic need_block; // byte position is zero
  } dp_sts_t;

  function automatic logic [31:0] rotl(input logic [31:0] v, input int n);
    rotl = (v << n) | (v >> (32 - n));
  endfunction
endpackage

// ===== hw/rtl/chacha_dp.sv =====
// Datapath: configuration registers, working state with four quarter-round
// lanes, keystream block store and byte position. Depends on chacha_pkg.
module chacha_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [chacha_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [chacha_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  chacha_pkg::dp_cmd_t                  cmd,
  input  logic                                 last_in,
  input  logic [7:0]                           data_in,
  output logic [7:0]                           ks_xor,
  output chacha_pkg::dp_sts_t                  sts
);
  import chacha_pkg::*;

  logic [63:0] key0_r, key1_r, key2_r, key3_r, nonce_lo_r;
  logic [31:0] nonce_hi_r, init_ctr_r;
  logic [5:0]  pos_r;
  logic [31:0] blk_r;
  logic [31:0] w_r [16];
  logic [31:0] init_r [16];
  logic [31:0] ks_r [16];
  logic [31:0] init_v [16];
  logic [31:0] w_nxt [16];
  logic [3:0]  ia [4], ib [4], ic [4], id [4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key0_r <= '0; key1_r <= '0; key2_r <= '0; key3_r <= '0;
      nonce_lo_r <= '0; nonce_hi_r <= '0; init_ctr_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_KEY0:     key0_r <= cfg_data;
        REG_KEY1:     key1_r <= cfg_data;
        REG_KEY2:     key2_r <= cfg_data;
        REG_KEY3:     key3_r <= cfg_data;
        REG_NONCE_LO: nonce_lo_r <= cfg_data;
        REG_NONCE_HI: nonce_hi_r <= cfg_data[31:0];
        REG_INIT_CTR: init_ctr_r <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    init_v[0] = SIGMA0; init_v[1] = SIGMA1; init_v[2] = SIGMA2; init_v[3] = SIGMA3;
    init_v[4] = key0_r[31:0]; init_v[5] = key0_r[63:32];
    init_v[6] = key1_r[31:0]; init_v[7] = key1_r[63:32];
    init_v[8] = key2_r[31:0]; init_v[9] = key2_r[63:32];
    init_v[10] = key3_r[31:0]; init_v[11] = key3_r[63:32];
    init_v[12] = init_ctr_r + blk_r;
    init_v[13] = nonce_lo_r[31:0]; init_v[14] = nonce_lo_r[63:32];
    init_v[15] = nonce_hi_r;
  end

  // Four quarter rounds side by side; lane j works on column j or diagonal j.
  always_comb begin
    logic [31:0] a, b, c, d;
    w_nxt = w_r;
    for (int j = 0; j < 4; j++) begin
      ia[j] = 4'(j);
      ib[j] = 4'(4 + (cmd.diag ? (j + 1) % 4 : j));
      ic[j] = 4'(8 + (cmd.diag ? (j + 2) % 4 : j));
      id[j] = 4'(12 + (cmd.diag ? (j + 3) % 4 : j));
      a = w_r[ia[j]]; b = w_r[ib[j]]; c = w_r[ic[j]]; d = w_r[id[j]];
      a = a + b; d = rotl(d ^ a, 16);
      c = c + d; b = rotl(b ^ c, 12);
      a = a + b; d = rotl(d ^ a, 8);
      c = c + d; b = rotl(b ^ c, 7);
      w_nxt[ia[j]] = a; w_nxt[ib[j]] = b; w_nxt[ic[j]] = c; w_nxt[id[j]] = d;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      w_r <= init_v;
      init_r <= init_v;
    end else if (cmd.round) begin
      w_r <= w_nxt;
    end
    if (cmd.finish) begin
      for (int i = 0; i < 16; i++) ks_r[i] <= w_r[i] + init_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      blk_r <= '0;
    end else if (cmd.advance) begin
      if (last_in) begin
        pos_r <= '0;
        blk_r <= '0;
      end else begin
        pos_r <= pos_r + 6'd1;
        if (pos_r == 6'd63) blk_r <= blk_r + 32'd1;
      end
    end
  end

  logic [31:0] word_sel;
  assign word_sel = ks_r[pos_r[5:2]];
  assign ks_xor = data_in ^ 8'(word_sel >> {pos_r[1:0], 3'b000});
  assign sts.need_block = (pos_r == 6'd0);
endmodule

// ===== hw/rtl/chacha_ctrl.sv =====
// Controller: sequences block generation and item handoff.
// Depends on chacha_pkg.
module chacha_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  chacha_pkg::dp_sts_t sts,
  output chacha_pkg::dp_cmd_t cmd,
  output logic                out_load
);
  import chacha_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_ROUND = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;
  localparam logic [1:0] ST_READY = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic [4:0] cnt_r, cnt_nxt;
  logic       ovalid_r, ovalid_nxt;
  logic       take;

  // An item is taken once the block is ready and the output slot is free.
  assign in_ready = (state_r == ST_READY) && (!ovalid_r || out_ready);
  assign take = in_valid && in_ready;
  assign out_valid = ovalid_r;
  assign out_load = take;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    ovalid_nxt = ovalid_r;
    cmd = '0;
    if (ovalid_r && out_ready) ovalid_nxt = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (sts.need_block && in_valid) begin
          cmd.load = 1'b1;
          cnt_nxt = '0;
          state_nxt = ST_ROUND;
        end else if (!sts.need_block) begin
          state_nxt = ST_READY;
        end
      end
      ST_ROUND: begin
        cmd.round = 1'b1;
        cmd.diag = cnt_r[0];
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'(2 * DOUBLE_ROUNDS - 1)) state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        cmd.finish = 1'b1;
        state_nxt = ST_READY;
      end
      ST_READY: begin
        if (take) begin
          cmd.advance = 1'b1;
          ovalid_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  a_take_ready: assert property (@(posedge clk) disable iff (!rst_n)
    take |-> state_r == ST_READY) else $error("item taken outside ready");
  a_round_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_ROUND |-> cnt_r < 5'(2 * DOUBLE_ROUNDS)) else $error("round overrun");
  a_finish: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_FINISH |=> state_r == ST_READY) else $error("finish not followed by ready");
endmodule

// ===== hw/rtl/chacha20_stream_cipher.sv =====
// ChaCha20 stream cipher (RFC 8439), one byte per item.
// Channels: in_* stream carries message bytes, out_* stream carries results,
// cfg_* is a write-only register port (index 0..6: key parts 0-3, nonce low,
// nonce high, initial counter). Write configuration only while idle.
// Each accepted byte gives one result: byte XOR keystream, last flag copied.
// A non-first byte of a block passes through the accept and then the idle
// state before the next byte is taken. The first byte of each 64-byte block
// waits for the block to be made: a load step, 20 half rounds on four
// quarter-round lanes and a feed-forward step. The last flag ends the
// message; the next byte starts again at the initial counter.
// The result sits in an output register; while the receiver stalls, one more
// item is held off until that register empties. Reset (rst_n, synchronous)
// clears configuration to zero, the position and block index, and the
// output valid; no clearing pass is needed.
// Depends on chacha_pkg, chacha_ctrl and chacha_dp.
module chacha20_stream_cipher (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [7:0]                        in_tdata,   // data_byte [7:0]
  input  logic                              in_tlast,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [7:0]                        out_tdata,  // cipher_byte [7:0]
  output logic                              out_tlast,
  input  logic                              cfg_we,
  input  logic [chacha_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [chacha_pkg::CFG_DATA_W-1:0] cfg_data
);
  import chacha_pkg::*;

  dp_cmd_t    cmd;
  dp_sts_t    sts;
  logic       out_load;
  logic [7:0] ks_xor;
  logic [7:0] odata_r;
  logic       olast_r;

  chacha_ctrl u_ctrl (
    .clk, .rst_n,
    .in_valid(in_tvalid), .in_ready(in_tready),
    .out_valid(out_tvalid), .out_ready(out_tready),
    .sts, .cmd, .out_load
  );

  chacha_dp u_dp (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data,
    .cmd, .last_in(in_tlast), .data_in(in_tdata), .ks_xor, .sts
  );

  always_ff @(posedge clk) begin
    if (out_load) begin
      odata_r <= ks_xor;
      olast_r <= in_tlast;
    end
  end

  assign out_tdata = odata_r;
  assign out_tlast = olast_r;
endmodule
